FILE: hdl/msmt_pkg.sv
// Shared types and constants for the matrix store / multiply / transpose block.
// Used by the channel interfaces and the top level; no dependencies.
package msmt_pkg;

  localparam int MAX_DIM_DEF   = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam logic [4:0] DIM_RESET = 5'd4;

  typedef enum logic [2:0] {
    ACT_WRITE_A   = 3'd0,
    ACT_READ_A    = 3'd1,
    ACT_WRITE_B   = 3'd2,
    ACT_TRANSPOSE = 3'd3,
    ACT_MULTIPLY  = 3'd4,
    ACT_SWAP_ROWS = 3'd5,
    ACT_SWAP_COLS = 3'd6,
    ACT_RESHAPE   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INDEX    = 2'd1,
    ST_DIMENSION = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_INIT_ROWS = 2'd0,
    REG_INIT_COLS = 2'd1,
    REG_B_ROWS    = 2'd2,
    REG_B_COLS    = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_TR_RD,
    S_TR_WR,
    S_CP_RD,
    S_CP_WR,
    S_M_RD,
    S_M_MUL,
    S_M_ACC,
    S_M_ST,
    S_SW_RD,
    S_SW_W1,
    S_SW_W2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [3:0]         first_index;
    logic [3:0]         second_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [4:0]         cur_rows;
    logic [4:0]         cur_cols;
  } out_item_t;

endpackage

FILE: hdl/msmt_if.sv
// Valid/ready channel interfaces for command and result transactions.
// Depends on msmt_pkg for the payload structs.
interface msmt_in_if;
  import msmt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface msmt_out_if;
  import msmt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/matrix_store_multiply_transpose.sv
// Matrix store with element access, transpose, multiply, swap and reshape.
// Depends on msmt_pkg and the channel interfaces in msmt_if.sv.
//
// Usage: commands arrive on req, one result transaction per command leaves
// on rsp. Shapes are set through the APB port (init_rows, init_cols, b_rows,
// b_cols at byte addresses 0, 4, 8, 12); the user must write them only while
// the block is idle, which the block does not enforce. One command is worked
// at a time; req.ready is high only in the idle state. The result sits in an
// output register, so the next command is taken while it waits; a finished
// command holds until that register is free.
// Per command (MAX_DIM = M, address space W = 2**(2*clog2(M))):
//   swap: read both elements, then write one and the other, per element
//   transpose: fill scratch over rows*cols, then copy back all M*M entries
//   multiply: read, multiply, accumulate per depth step, store to scratch,
//             then copy back; one shared 32x32 multiplier and one accumulator
//   reshape: clearing sweep of A over all W entries, one entry per cycle
// Reset starts the same clearing sweep of A; req.ready stays low until done.
// A stalled receiver holds the result register and, once a second result is
// finished, the sequencer.
module matrix_store_multiply_transpose #(
  parameter int MAX_DIM   = msmt_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = msmt_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  msmt_in_if.sink     req,
  msmt_out_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import msmt_pkg::*;

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int AW    = 2 * IW;
  localparam int ACC_W = 64 + IW + 1;

  function automatic logic [DW-1:0] clamp_dim(input logic [4:0] v);
    logic [DW-1:0] res;
    if (v == 5'd0) res = DW'(1);
    else if (int'(v) > MAX_DIM) res = DW'(MAX_DIM);
    else res = DW'(v);
    return res;
  endfunction

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return {r, c};
  endfunction

  // configuration registers
  logic [4:0] init_rows, init_cols, b_rows, b_cols;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_rows <= DIM_RESET;
      init_cols <= DIM_RESET;
      b_rows    <= DIM_RESET;
      b_cols    <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (reg_index_t'(paddr[3:2]))
        REG_INIT_ROWS: init_rows <= pwdata[4:0];
        REG_INIT_COLS: init_cols <= pwdata[4:0];
        REG_B_ROWS:    b_rows    <= pwdata[4:0];
        REG_B_COLS:    b_cols    <= pwdata[4:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[3:2]))
      REG_INIT_ROWS: prdata = {27'd0, init_rows};
      REG_INIT_COLS: prdata = {27'd0, init_cols};
      REG_B_ROWS:    prdata = {27'd0, b_rows};
      REG_B_COLS:    prdata = {27'd0, b_cols};
      default:       prdata = 32'd0;
    endcase
  end

  // sequencer state and datapath registers
  state_t              state, state_next;
  in_item_t            it;
  logic                busy;
  logic [DW-1:0]       rows, cols;
  logic [IW-1:0]       r, c, k;
  logic [AW-1:0]       clr;
  logic [31:0]         res_read_value;
  logic [1:0]          res_status;
  logic signed [63:0]  prod;
  logic signed [ACC_W-1:0] acc, acc_sh;
  logic [31:0]         sat_val;
  logic                out_free;

  // memories
  logic [31:0] a_mem [2**AW];
  logic [31:0] b_mem [2**AW];
  logic [31:0] s_mem [2**AW];
  logic          a_we, b_we, s_we;
  logic [AW-1:0] a_waddr, a_raddr1, a_raddr2, b_waddr, b_raddr, s_waddr, s_raddr;
  logic [31:0]   a_wdata, b_wdata, s_wdata;
  logic [31:0]   a_rdata1, a_rdata2, b_rdata, s_rdata;

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= a_wdata;
    a_rdata1 <= a_mem[a_raddr1];
    a_rdata2 <= a_mem[a_raddr2];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_waddr] <= b_wdata;
    b_rdata <= b_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_waddr] <= s_wdata;
    s_rdata <= s_mem[s_raddr];
  end

  // command checks on the incoming payload
  logic [DW-1:0] br, bc;
  logic a_in, b_in, sr_ok, sc_ok, mul_ok, accept;
  logic sw_rows;
  logic [DW-1:0] sw_len;
  logic [IW-1:0] sw_first, sw_second;

  assign br     = clamp_dim(b_rows);
  assign bc     = clamp_dim(b_cols);
  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign a_in   = (int'(req.payload.row) < int'(rows)) && (int'(req.payload.col) < int'(cols));
  assign b_in   = (int'(req.payload.row) < int'(br)) && (int'(req.payload.col) < int'(bc));
  assign sr_ok  = (int'(req.payload.first_index) < int'(rows)) &&
                  (int'(req.payload.second_index) < int'(rows));
  assign sc_ok  = (int'(req.payload.first_index) < int'(cols)) &&
                  (int'(req.payload.second_index) < int'(cols));
  assign mul_ok = (cols == br);

  assign sw_rows   = (action_t'(it.action) == ACT_SWAP_ROWS);
  assign sw_len    = sw_rows ? cols : rows;
  assign sw_first  = IW'(it.first_index);
  assign sw_second = IW'(it.second_index);

  // floor shift and saturate the accumulated sum
  assign acc_sh = acc >>> FRAC_BITS;
  always_comb begin
    if ((&acc_sh[ACC_W-1:31]) || !(|acc_sh[ACC_W-1:31])) sat_val = acc_sh[31:0];
    else if (acc_sh[ACC_W-1]) sat_val = Q_MIN;
    else sat_val = Q_MAX;
  end

  logic c_last_shape, r_last_shape, c_last_full, r_last_full, k_last, sw_last, cp_in;
  assign c_last_shape = (int'(c) == int'(cols) - 1);
  assign r_last_shape = (int'(r) == int'(rows) - 1);
  assign c_last_full  = (int'(c) == MAX_DIM - 1);
  assign r_last_full  = (int'(r) == MAX_DIM - 1);
  assign k_last       = (int'(k) == int'(cols) - 1);
  assign sw_last      = (int'(k) == int'(sw_len) - 1);
  assign cp_in        = (int'(r) < int'(rows)) && (int'(c) < int'(cols));
  assign out_free     = !rsp.valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (&clr) state_next = busy ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (req.valid) begin
          unique case (action_t'(req.payload.action))
            ACT_READ_A:    state_next = a_in ? S_READ : S_DONE;
            ACT_TRANSPOSE: state_next = S_TR_RD;
            ACT_MULTIPLY:  state_next = mul_ok ? S_M_RD : S_DONE;
            ACT_SWAP_ROWS: state_next = sr_ok ? S_SW_RD : S_DONE;
            ACT_SWAP_COLS: state_next = sc_ok ? S_SW_RD : S_DONE;
            ACT_RESHAPE:   state_next = S_CLEAR;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_READ:  state_next = S_DONE;
      S_TR_RD: state_next = S_TR_WR;
      S_TR_WR: state_next = (c_last_shape && r_last_shape) ? S_CP_RD : S_TR_RD;
      S_CP_RD: state_next = S_CP_WR;
      S_CP_WR: state_next = (c_last_full && r_last_full) ? S_DONE : S_CP_RD;
      S_M_RD:  state_next = S_M_MUL;
      S_M_MUL: state_next = S_M_ACC;
      S_M_ACC: state_next = k_last ? S_M_ST : S_M_RD;
      S_M_ST: begin
        if ((int'(c) == int'(bc) - 1) && r_last_shape) state_next = S_CP_RD;
        else state_next = S_M_RD;
      end
      S_SW_RD: state_next = S_SW_W1;
      S_SW_W1: state_next = S_SW_W2;
      S_SW_W2: state_next = sw_last ? S_DONE : S_SW_RD;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_raddr1 = '0; a_raddr2 = '0;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        a_we = 1'b1; a_waddr = clr;
      end
      S_IDLE: begin
        a_raddr1 = addr(IW'(req.payload.row), IW'(req.payload.col));
        a_waddr  = a_raddr1;
        a_wdata  = req.payload.value;
        a_we     = req.valid && (action_t'(req.payload.action) == ACT_WRITE_A) && a_in;
        b_waddr  = addr(IW'(req.payload.row), IW'(req.payload.col));
        b_wdata  = req.payload.value;
        b_we     = req.valid && (action_t'(req.payload.action) == ACT_WRITE_B) && b_in;
      end
      S_TR_RD: a_raddr1 = addr(r, c);
      S_TR_WR: begin
        s_we = 1'b1; s_waddr = addr(c, r); s_wdata = a_rdata1;
      end
      S_CP_RD: s_raddr = addr(r, c);
      S_CP_WR: begin
        a_we = 1'b1; a_waddr = addr(r, c); a_wdata = cp_in ? s_rdata : 32'd0;
      end
      S_M_RD: begin
        a_raddr1 = addr(r, k);
        b_raddr  = addr(k, c);
      end
      S_M_ST: begin
        s_we = 1'b1; s_waddr = addr(r, c); s_wdata = sat_val;
      end
      S_SW_RD, S_SW_W1, S_SW_W2: begin
        a_raddr1 = sw_rows ? addr(sw_first, k) : addr(k, sw_first);
        a_raddr2 = sw_rows ? addr(sw_second, k) : addr(k, sw_second);
        if (state == S_SW_W1) begin
          a_we = 1'b1; a_waddr = a_raddr1; a_wdata = a_rdata2;
        end else if (state == S_SW_W2) begin
          a_we = 1'b1; a_waddr = a_raddr2; a_wdata = a_rdata1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b0;
      clr   <= '0;
      rows  <= clamp_dim(DIM_RESET);
      cols  <= clamp_dim(DIM_RESET);
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr <= clr + AW'(1);
        S_IDLE: begin
          if (accept) begin
            busy <= 1'b1;
            clr  <= '0;
            r <= '0; c <= '0; k <= '0;
            acc <= '0;
            if (action_t'(req.payload.action) == ACT_RESHAPE) begin
              rows <= clamp_dim(init_rows);
              cols <= clamp_dim(init_cols);
            end
          end
        end
        S_TR_WR: begin
          if (c_last_shape) begin
            c <= '0;
            if (r_last_shape) begin
              r <= '0;
              rows <= cols;
              cols <= rows;
            end else begin
              r <= r + IW'(1);
            end
          end else begin
            c <= c + IW'(1);
          end
        end
        S_CP_WR: begin
          if (c_last_full) begin
            c <= '0;
            r <= r + IW'(1);
          end else begin
            c <= c + IW'(1);
          end
        end
        S_M_MUL: prod <= signed'(a_rdata1) * signed'(b_rdata);
        S_M_ACC: begin
          acc <= acc + {{(ACC_W-64){prod[63]}}, prod};
          if (!k_last) k <= k + IW'(1);
        end
        S_M_ST: begin
          acc <= '0;
          k   <= '0;
          if (int'(c) == int'(bc) - 1) begin
            c <= '0;
            if (r_last_shape) begin
              r    <= '0;
              cols <= bc;
            end else begin
              r <= r + IW'(1);
            end
          end else begin
            c <= c + IW'(1);
          end
        end
        S_SW_W2: k <= k + IW'(1);
        S_DONE:  if (out_free) busy <= 1'b0;
        default: ;
      endcase
    end
  end

  // result fields, captured alongside the command; the value of read A is captured in the read state
  always_ff @(posedge clk) begin
    if (accept) begin
      it             <= req.payload;
      res_read_value <= 32'd0;
      res_status     <= ST_OK;
      unique case (action_t'(req.payload.action))
        ACT_WRITE_A, ACT_READ_A: if (!a_in) res_status <= ST_INDEX;
        ACT_WRITE_B:   if (!b_in) res_status <= ST_INDEX;
        ACT_MULTIPLY:  if (!mul_ok) res_status <= ST_DIMENSION;
        ACT_SWAP_ROWS: if (!sr_ok) res_status <= ST_INDEX;
        ACT_SWAP_COLS: if (!sc_ok) res_status <= ST_INDEX;
        default:       ;
      endcase
    end else if (state == S_READ) begin
      res_read_value <= a_rdata1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.payload.read_value <= res_read_value;
      rsp.payload.status     <= res_status;
      rsp.payload.cur_rows   <= 5'(rows);
      rsp.payload.cur_cols   <= 5'(cols);
    end
  end

endmodule

FILE: test/msmt_checker.sv
// Result checker for the matrix store / multiply / transpose block: predicts each
// result from the accepted commands and APB writes. Depends on msmt_pkg and msmt_if.
module msmt_checker (
  input  logic        clk,
  input  logic        rst,
  msmt_in_if          req,
  msmt_out_if         rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import msmt_pkg::*;

  localparam int M = MAX_DIM_DEF;
  localparam int FB = FRAC_BITS_DEF;

  logic [31:0] a_mem [M*M];
  logic [31:0] b_mem [M*M];
  logic [4:0]  a_rows, a_cols;
  logic [4:0]  cfg_init_rows, cfg_init_cols, cfg_b_rows, cfg_b_cols;
  out_item_t   pending_results [$];

  function automatic logic [4:0] clamp_dim(logic [4:0] v);
    if (v < 5'd1) return 5'd1;
    if (v > 5'(M)) return 5'(M);
    return v;
  endfunction

  function automatic logic [31:0] dot_q(int r, int c, int depth);
    logic signed [127:0] acc;
    logic signed [127:0] sh;
    logic signed [63:0]  p;
    acc = '0;
    for (int k = 0; k < depth; k++) begin
      p = $signed(a_mem[r*M+k]) * $signed(b_mem[k*M+c]);
      acc += p;
    end
    sh = acc >>> FB;
    if (sh > 128'sd2147483647) return Q_MAX;
    if (sh < -128'sd2147483648) return Q_MIN;
    return sh[31:0];
  endfunction

  // Apply one command to the shadow state and return its result.
  function automatic out_item_t apply_command(in_item_t c);
    out_item_t   r;
    logic [31:0] nxt [M*M];
    logic [31:0] t;
    logic [4:0]  br, bc, tmp;
    br = clamp_dim(cfg_b_rows);
    bc = clamp_dim(cfg_b_cols);
    r = '0;
    r.status = ST_OK;
    case (action_t'(c.action))
      ACT_WRITE_A, ACT_READ_A: begin
        if (c.row >= a_rows || c.col >= a_cols) r.status = ST_INDEX;
        else if (c.action == ACT_WRITE_A) a_mem[c.row*M+c.col] = c.value;
        else r.read_value = a_mem[c.row*M+c.col];
      end
      ACT_WRITE_B: begin
        if (c.row >= br || c.col >= bc) r.status = ST_INDEX;
        else b_mem[c.row*M+c.col] = c.value;
      end
      ACT_TRANSPOSE: begin
        foreach (nxt[i]) nxt[i] = '0;
        for (int i = 0; i < a_rows; i++)
          for (int j = 0; j < a_cols; j++) nxt[j*M+i] = a_mem[i*M+j];
        a_mem = nxt;
        tmp = a_rows;
        a_rows = a_cols;
        a_cols = tmp;
      end
      ACT_MULTIPLY: begin
        if (a_cols != br) begin
          r.status = ST_DIMENSION;
        end else begin
          foreach (nxt[i]) nxt[i] = '0;
          for (int i = 0; i < a_rows; i++)
            for (int j = 0; j < bc; j++) nxt[i*M+j] = dot_q(i, j, a_cols);
          a_mem = nxt;
          a_cols = bc;
        end
      end
      ACT_SWAP_ROWS: begin
        if (c.first_index >= a_rows || c.second_index >= a_rows) begin
          r.status = ST_INDEX;
        end else begin
          for (int j = 0; j < a_cols; j++) begin
            t = a_mem[c.first_index*M+j];
            a_mem[c.first_index*M+j] = a_mem[c.second_index*M+j];
            a_mem[c.second_index*M+j] = t;
          end
        end
      end
      ACT_SWAP_COLS: begin
        if (c.first_index >= a_cols || c.second_index >= a_cols) begin
          r.status = ST_INDEX;
        end else begin
          for (int i = 0; i < a_rows; i++) begin
            t = a_mem[i*M+c.first_index];
            a_mem[i*M+c.first_index] = a_mem[i*M+c.second_index];
            a_mem[i*M+c.second_index] = t;
          end
        end
      end
      default: begin
        foreach (a_mem[i]) a_mem[i] = '0;
        a_rows = clamp_dim(cfg_init_rows);
        a_cols = clamp_dim(cfg_init_cols);
      end
    endcase
    r.cur_rows = a_rows;
    r.cur_cols = a_cols;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: result %s mismatch: got %0h, want %0h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want, got;
    if (rst) begin
      foreach (a_mem[i]) a_mem[i] = '0;
      foreach (b_mem[i]) b_mem[i] = '0;
      a_rows = DIM_RESET;
      a_cols = DIM_RESET;
      cfg_init_rows = DIM_RESET;
      cfg_init_cols = DIM_RESET;
      cfg_b_rows = DIM_RESET;
      cfg_b_cols = DIM_RESET;
      pending_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[3:2]))
          REG_INIT_ROWS: cfg_init_rows = pwdata[4:0];
          REG_INIT_COLS: cfg_init_cols = pwdata[4:0];
          REG_B_ROWS:    cfg_b_rows = pwdata[4:0];
          default:       cfg_b_cols = pwdata[4:0];
        endcase
      end
      if (req.valid && req.ready) pending_results.push_back(apply_command(req.payload));
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (pending_results.size() == 0) begin
          $display("%0t: result transaction with nothing pending", $realtime);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.cur_rows !== want.cur_rows)
            report_mismatch("cur_rows", got.cur_rows, want.cur_rows);
          if (got.cur_cols !== want.cur_cols)
            report_mismatch("cur_cols", got.cur_cols, want.cur_cols);
        end
      end
    end
    outstanding = pending_results.size();
  end

  initial begin
    errors = 0;
    outstanding = 0;
  end

endmodule

FILE: test/matrix_store_multiply_transpose_tb.sv
// Top of the matrix store / multiply / transpose testbench: clock, reset, APB setup,
// command stimulus and verdict. Depends on msmt_pkg, msmt_if, msmt_checker and the RTL.
module matrix_store_multiply_transpose_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msmt_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, outstanding;
  int          cycles;
  int          burst_left;
  int          ready_mode, mode_left;

  msmt_in_if  req ();
  msmt_out_if rsp ();

  matrix_store_multiply_transpose i_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  msmt_checker i_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix_store_multiply_transpose_tb NOT OK");
      $finish;
    end
  end

  // Receiver stall pattern: switch between always ready, random, and long holds.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(8, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0:       rsp.ready <= 1'b1;
      1:       rsp.ready <= 1'($urandom_range(0, 1));
      2:       rsp.ready <= ($urandom_range(0, 7) == 0);
      default: rsp.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic apb_write(reg_index_t idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drive one command; a pending gap is taken first, in the step of the last transaction.
  task automatic send_cmd(in_item_t c);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      req.valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 5)) @(posedge clk);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.payload <= c;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    // let the checker count the last accepted command before polling
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t make_cmd(action_t act, int r, int c, int f, int s,
                                        logic [31:0] v);
    in_item_t x;
    x.action = act;
    x.row = 4'(r);
    x.col = 4'(c);
    x.first_index = 4'(f);
    x.second_index = 4'(s);
    x.value = v;
    return x;
  endfunction

  function automatic logic [31:0] rand_value();
    int k;
    k = $urandom_range(0, 19);
    if (k < 13) return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
    if (k == 13) return Q_MAX;
    if (k == 14) return Q_MIN;
    if (k == 15) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic int pick_idx(int lim);
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, lim);
    return $urandom_range(0, 15);
  endfunction

  function automatic in_item_t rand_cmd(int lim, int mul_pct);
    int      k;
    action_t act;
    k = $urandom_range(0, 99);
    if (k < mul_pct) act = ACT_MULTIPLY;
    else if (k < 35) act = ACT_WRITE_A;
    else if (k < 60) act = ACT_READ_A;
    else if (k < 70) act = ACT_WRITE_B;
    else if (k < 76) act = ACT_TRANSPOSE;
    else if (k < 85) act = ACT_SWAP_ROWS;
    else if (k < 94) act = ACT_SWAP_COLS;
    else if (k < 97) act = ACT_RESHAPE;
    else act = action_t'(3'($urandom_range(0, 7)));
    return make_cmd(act, pick_idx(lim), pick_idx(lim), pick_idx(lim), pick_idx(lim),
                    rand_value());
  endfunction

  // Set all four shapes, reshape A, load every element of B, then random commands.
  task automatic run_phase(logic [4:0] ir, logic [4:0] ic, logic [4:0] br, logic [4:0] bc,
                           int n, int mul_pct);
    int rb, cb, lim;
    drain();
    apb_write(REG_INIT_ROWS, 32'(ir));
    apb_write(REG_INIT_COLS, 32'(ic));
    apb_write(REG_B_ROWS, 32'(br));
    apb_write(REG_B_COLS, 32'(bc));
    rb = (br == 0) ? 1 : (br > 16) ? 16 : br;
    cb = (bc == 0) ? 1 : (bc > 16) ? 16 : bc;
    lim = rb;
    if (cb > lim) lim = cb;
    if (ir > lim) lim = (ir > 16) ? 16 : ir;
    if (ic > lim) lim = (ic > 16) ? 16 : ic;
    lim = lim - 1;
    send_cmd(make_cmd(ACT_RESHAPE, 0, 0, 0, 0, 0));
    for (int r = 0; r < rb; r++)
      for (int c = 0; c < cb; c++) send_cmd(make_cmd(ACT_WRITE_B, r, c, 0, 0, rand_value()));
    for (int i = 0; i < n; i++) send_cmd(rand_cmd(lim, mul_pct));
  endtask

  initial begin
    cycles = 0;
    burst_left = 0;
    ready_mode = 0;
    mode_left = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: 4x4 reset shape, extremes, range errors, swaps, transpose, saturation.
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_cmd(make_cmd(ACT_WRITE_B, r, c, 0, 0, ((r + c) % 2 == 0) ? Q_MAX : Q_MIN));
    send_cmd(make_cmd(ACT_WRITE_B, 4, 0, 0, 0, 32'h1));
    send_cmd(make_cmd(ACT_WRITE_A, 0, 0, 0, 0, Q_MAX));
    send_cmd(make_cmd(ACT_WRITE_A, 3, 3, 0, 0, Q_MIN));
    send_cmd(make_cmd(ACT_WRITE_A, 1, 2, 0, 0, 32'h0001_8000));
    send_cmd(make_cmd(ACT_READ_A, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_READ_A, 3, 3, 0, 0, 0));
    send_cmd(make_cmd(ACT_WRITE_A, 4, 0, 0, 0, 32'h5));
    send_cmd(make_cmd(ACT_READ_A, 0, 15, 0, 0, 0));
    send_cmd(make_cmd(ACT_SWAP_ROWS, 0, 0, 0, 3, 0));
    send_cmd(make_cmd(ACT_SWAP_ROWS, 0, 0, 2, 2, 0));
    send_cmd(make_cmd(ACT_SWAP_ROWS, 0, 0, 0, 4, 0));
    send_cmd(make_cmd(ACT_SWAP_COLS, 0, 0, 1, 3, 0));
    send_cmd(make_cmd(ACT_SWAP_COLS, 0, 0, 15, 0, 0));
    send_cmd(make_cmd(ACT_TRANSPOSE, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_MULTIPLY, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_READ_A, 0, 3, 0, 0, 0));
    send_cmd(make_cmd(ACT_READ_A, 3, 0, 0, 0, 0));
    for (int i = 0; i < 250; i++) send_cmd(rand_cmd(4, 8));

    run_phase(5'd3, 5'd5, 5'd5, 5'd2, 250, 8);
    send_cmd(make_cmd(ACT_MULTIPLY, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_MULTIPLY, 0, 0, 0, 0, 0));
    run_phase(5'd1, 5'd1, 5'd1, 5'd1, 200, 8);
    run_phase(5'd16, 5'd16, 5'd16, 5'd16, 120, 3);
    run_phase(5'd0, 5'd31, 5'd31, 5'd0, 200, 8);
    run_phase(5'd2, 5'd7, 5'd7, 5'd3, 300, 8);
    run_phase(5'd4, 5'd4, 5'd4, 5'd4, 200, 8);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("matrix_store_multiply_transpose_tb OK");
    end else begin
      $display("matrix_store_multiply_transpose_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/msmt_pkg.sv
hdl/msmt_if.sv
hdl/matrix_store_multiply_transpose.sv
test/msmt_checker.sv
test/matrix_store_multiply_transpose_tb.sv
